// ----- rtl/hadr_pkg.sv -----
`default_nettype none
// ============================================================================
// hadr_pkg: shared types and constants for the ambient delta ranker
// Field widths, register indexes, queue entry and divider request types.
// ============================================================================
package hadr_pkg;

    localparam int VAL_W  = 24;
    localparam int Q_W    = 32;
    localparam int WIDE_W = 40;
    localparam int ROW_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 2'd2;

    localparam logic OP_PROP  = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    typedef struct packed {
        logic             is_count;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] value;
        logic             cell_end;
    } hadr_item_t;

    typedef struct packed {
        logic       valid;
        hadr_item_t item;
    } hadr_qhead_t;

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  hi;
        logic [Q_W-1:0]    lo;
        logic [WIDE_W-1:0] den;
    } hadr_div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } hadr_div_rsp_t;

    typedef struct packed {
        logic [4:0]        rows;
        logic [3:0]        expected;
        logic [WIDE_W-1:0] pseudo_floor;
    } hadr_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/hadr_in_if.sv -----
`default_nettype none
// ============================================================================
// hadr_in_if: input channel of the ambient delta ranker
// Valid/ready channel carrying proportion writes and counts.
// ============================================================================
interface hadr_in_if;
    import hadr_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] sample_value;
    logic             cell_end;

    modport source (output valid, output op, output row, output sample_value,
                    output cell_end, input ready);
    modport sink (input valid, input op, input row, input sample_value,
                  input cell_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/hadr_out_if.sv -----
`default_nettype none
// ============================================================================
// hadr_out_if: result channel of the ambient delta ranker
// Valid/ready channel carrying one ranked row and the cell statistics.
// ============================================================================
interface hadr_out_if;
    import hadr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  best_index;
    logic              best_valid;
    logic [Q_W-1:0]    fold_change;
    logic              fold_valid;
    logic [ROW_W-1:0]  second_index;
    logic              second_valid;
    logic [WIDE_W-1:0] second_value;
    logic [Q_W-1:0]    second_over_ambient;
    logic [WIDE_W-1:0] ambient_level;
    logic              prop_error;
    logic              run_last;

    modport source (output valid, output best_index, output best_valid,
                    output fold_change, output fold_valid, output second_index,
                    output second_valid, output second_value,
                    output second_over_ambient, output ambient_level,
                    output prop_error, output run_last, input ready);
    modport sink (input valid, input best_index, input best_valid,
                  input fold_change, input fold_valid, input second_index,
                  input second_valid, input second_value,
                  input second_over_ambient, input ambient_level,
                  input prop_error, input run_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/hadr_front.sv -----
`default_nettype none
// ============================================================================
// hadr_front: input acceptance and classification
// Drops out-of-table proportion writes and queues the rest in two entries.
// ============================================================================
module hadr_front #(
    parameter int MAX_ROWS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    hadr_in_if.sink             in_ch,
    output hadr_pkg::hadr_qhead_t head,
    input  wire logic           pop
);
    import hadr_pkg::*;

    hadr_item_t q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       accept;
    logic       keep;
    logic       push;
    hadr_item_t new_item;

    assign in_ch.ready = (fill_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;
    // A proportion write beyond the table has no effect and is not queued.
    assign keep        = (in_ch.op == OP_COUNT) || (32'(in_ch.row) < MAX_ROWS);
    assign push        = accept && keep;

    always_comb
    begin
        new_item.is_count = (in_ch.op == OP_COUNT);
        new_item.row      = in_ch.row;
        new_item.value    = in_ch.sample_value;
        new_item.cell_end = in_ch.cell_end;
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !(pop && head.valid))
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && pop && head.valid)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && head.valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hadr_div.sv -----
`default_nettype none
// ============================================================================
// hadr_div: shared saturating radix-2 divider
// Divides {hi, lo} by den one quotient bit per cycle, saturating to 32 bits.
// ============================================================================
module hadr_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  hadr_pkg::hadr_div_req_t req,
    output hadr_pkg::hadr_div_rsp_t rsp
);
    import hadr_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] den_reg;
    logic [Q_W-1:0]    lo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WIDE_W:0]   trial;
    logic              fits;

    // The divisor is held for the whole division, as the request is only
    // presented in the start cycle.
    assign trial = {rem_reg, lo_reg[Q_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign rsp.done = done_reg;
    assign rsp.quo  = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // The quotient overflows exactly when the upper part reaches the divisor.
                if (WIDE_W'(req.hi) >= req.den)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= WIDE_W'(req.hi);
            den_reg <= req.den;
            lo_reg  <= (WIDE_W'(req.hi) >= req.den) ? '1 : req.lo;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= WIDE_W'(trial - {1'b0, den_reg});
                lo_reg  <= {lo_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WIDE_W-1:0];
                lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hadr_back.sv -----
`default_nettype none
// ============================================================================
// hadr_back: per-cell evaluation sequencer
// Stores tables, derives scaling and ambient, ranks rows and emits results.
// ============================================================================
module hadr_back #(
    parameter int MAX_ROWS     = 16,
    parameter int MAX_EXPECTED = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  hadr_pkg::hadr_cfg_t    cfg,
    input  hadr_pkg::hadr_qhead_t  head,
    output logic                   pop,
    output hadr_pkg::hadr_div_req_t div_req,
    input  hadr_pkg::hadr_div_rsp_t div_rsp,
    hadr_out_if.source             out_ch
);
    import hadr_pkg::*;

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int KW = ((CW > 6) ? CW : 6) + 1;
    localparam int SW = VAL_W + CW;
    localparam int PW = Q_W + VAL_W;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_RAT_GO    = 5'd1;
    localparam logic [4:0] S_RAT_WAIT  = 5'd2;
    localparam logic [4:0] S_SEL_LOAD  = 5'd3;
    localparam logic [4:0] S_SEL_CMP   = 5'd4;
    localparam logic [4:0] S_SEL_END   = 5'd5;
    localparam logic [4:0] S_MEAN_GO   = 5'd6;
    localparam logic [4:0] S_MEAN_WAIT = 5'd7;
    localparam logic [4:0] S_AMB_MUL   = 5'd8;
    localparam logic [4:0] S_AMB       = 5'd9;
    localparam logic [4:0] S_CORR_MUL  = 5'd10;
    localparam logic [4:0] S_CORR_ADD  = 5'd11;
    localparam logic [4:0] S_RANK_LOAD = 5'd12;
    localparam logic [4:0] S_RANK_CMP  = 5'd13;
    localparam logic [4:0] S_RANK_END  = 5'd14;
    localparam logic [4:0] S_FC_GO     = 5'd15;
    localparam logic [4:0] S_FC_WAIT   = 5'd16;
    localparam logic [4:0] S_SOA_GO    = 5'd17;
    localparam logic [4:0] S_SOA_WAIT  = 5'd18;
    localparam logic [4:0] S_EMIT      = 5'd19;

    logic [VAL_W-1:0]  prop_mem  [MAX_ROWS];
    logic [VAL_W-1:0]  cnt_mem   [MAX_ROWS];
    logic [Q_W-1:0]    ratio_mem [MAX_ROWS];
    logic [WIDE_W-1:0] corr_mem  [MAX_ROWS];
    logic [KW-1:0]     pos_mem   [MAX_ROWS];

    logic [4:0]  state_reg, state_next;
    logic [KW-1:0] idx_reg, idx_next;
    logic [KW-1:0] jdx_reg, jdx_next;
    logic [KW-1:0] kcnt_reg, kcnt_next;
    logic [KW-1:0] ptr_reg, ptr_next;
    logic          ovalid_reg, ovalid_next;
    logic          load_out;

    logic [SW-1:0]     sum_reg;
    logic              perr_reg;
    logic [WIDE_W-1:0] cur_reg;
    logic [KW-1:0]     gt_reg;
    logic [KW-1:0]     ge_reg;
    logic [Q_W-1:0]    sela_reg;
    logic [Q_W-1:0]    selb_reg;
    logic [Q_W-1:0]    scaling_reg;
    logic [VAL_W-1:0]  mean_reg;
    logic [PW-1:0]     prod_reg;
    logic [WIDE_W-1:0] obs_reg;
    logic [WIDE_W-1:0] amb_reg;
    logic [WIDE_W-1:0] vala_reg;
    logic [WIDE_W-1:0] valb_reg;
    logic [KW-1:0]     sidx_reg;
    logic [Q_W-1:0]    fc_reg;
    logic [Q_W-1:0]    soa_reg;

    logic [ROW_W-1:0]  o_best_index_reg;
    logic              o_best_valid_reg;
    logic [Q_W-1:0]    o_fold_change_reg;
    logic              o_fold_valid_reg;
    logic [ROW_W-1:0]  o_second_index_reg;
    logic              o_second_valid_reg;
    logic [WIDE_W-1:0] o_second_value_reg;
    logic [Q_W-1:0]    o_soa_reg;
    logic [WIDE_W-1:0] o_ambient_reg;
    logic              o_perr_reg;
    logic              o_last_reg;

    logic [KW-1:0] rows_ext, exp_ext, nr, ne, half, two_ne, fb, ka, kb;
    logic          use_med, even, bv, fv, sv, last_i, last_j, cand, can_load;
    logic [IW-1:0] i_addr, rat_addr, corr_addr;
    logic [VAL_W-1:0]  prop_rd, cnt_rd;
    logic [Q_W-1:0]    rat_rd;
    logic [WIDE_W-1:0] corr_rd, ex_val, diff;
    logic [WIDE_W:0]   corr_sum;
    logic [WIDE_W-1:0] corr_sat;
    logic [KW-1:0]     pos_rd;
    logic [Q_W:0]      pair_sum;

    // Clamp the configuration into the legal ranges.
    assign rows_ext = KW'(cfg.rows);
    assign exp_ext  = KW'(cfg.expected);
    assign nr = (rows_ext == '0) ? KW'(1) :
                (rows_ext > KW'(MAX_ROWS)) ? KW'(MAX_ROWS) : rows_ext;
    assign ne = (exp_ext == '0) ? KW'(1) :
                (exp_ext > KW'(MAX_EXPECTED)) ? KW'(MAX_EXPECTED) : exp_ext;

    assign half    = nr >> 1;
    assign two_ne  = ne << 1;
    assign fb      = (two_ne > nr - KW'(1)) ? nr - KW'(1) : two_ne;
    assign use_med = (half > fb);
    assign even    = !nr[0];
    assign ka      = use_med ? (even ? half - KW'(1) : half) : fb;
    assign kb      = use_med ? half : fb;
    assign bv      = (nr >= ne);
    assign fv      = (nr > ne);
    assign sv      = (nr > two_ne);
    assign last_i  = (idx_reg == nr - KW'(1));
    assign last_j  = (jdx_reg == nr - KW'(1));

    assign i_addr    = idx_reg[IW-1:0];
    assign rat_addr  = (state_reg == S_SEL_LOAD) ? idx_reg[IW-1:0] : jdx_reg[IW-1:0];
    assign corr_addr = (state_reg == S_RANK_LOAD) ? idx_reg[IW-1:0] : jdx_reg[IW-1:0];
    assign prop_rd   = prop_mem[i_addr];
    assign cnt_rd    = cnt_mem[i_addr];
    assign pos_rd    = pos_mem[i_addr];
    assign rat_rd    = ratio_mem[rat_addr];
    assign corr_rd   = corr_mem[corr_addr];

    assign pair_sum = {1'b0, sela_reg} + {1'b0, selb_reg};
    assign ex_val   = prod_reg[PW-1:16];
    assign diff     = (obs_reg > ex_val) ? obs_reg - ex_val : '0;
    assign corr_sum = {1'b0, diff} + {1'b0, amb_reg};
    assign corr_sat = corr_sum[WIDE_W] ? '1 : corr_sum[WIDE_W-1:0];

    assign cand     = !bv || (pos_rd < ne);
    assign can_load = !ovalid_reg || out_ch.ready;

    // Divider operand selection.
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.hi    = '0;
        div_req.lo    = '0;
        div_req.den   = '0;
        unique case (state_reg)
            S_RAT_GO:
            begin
                div_req.start = 1'b1;
                div_req.hi    = cnt_rd;
                div_req.den   = WIDE_W'(prop_rd);
            end
            S_MEAN_GO:
            begin
                div_req.start = 1'b1;
                div_req.lo    = Q_W'(sum_reg);
                div_req.den   = WIDE_W'(nr);
            end
            S_FC_GO:
            begin
                div_req.start = fv;
                div_req.hi    = vala_reg[WIDE_W-1:16];
                div_req.lo    = {vala_reg[15:0], 16'd0};
                div_req.den   = valb_reg;
            end
            S_SOA_GO:
            begin
                div_req.start = sv;
                div_req.hi    = valb_reg[WIDE_W-1:16];
                div_req.lo    = {valb_reg[15:0], 16'd0};
                div_req.den   = amb_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        jdx_next    = jdx_reg;
        kcnt_next   = kcnt_reg;
        ptr_next    = ptr_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        pop         = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.is_count)
                    begin
                        if (ptr_reg < KW'(MAX_ROWS))
                        begin
                            ptr_next = ptr_reg + KW'(1);
                        end
                        if (head.item.cell_end)
                        begin
                            ptr_next   = '0;
                            idx_next   = '0;
                            state_next = S_RAT_GO;
                        end
                    end
                end
            end
            S_RAT_GO:
            begin
                state_next = S_RAT_WAIT;
            end
            S_RAT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (last_i)
                    begin
                        idx_next   = '0;
                        state_next = S_SEL_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + KW'(1);
                        state_next = S_RAT_GO;
                    end
                end
            end
            S_SEL_LOAD:
            begin
                jdx_next   = '0;
                state_next = S_SEL_CMP;
            end
            S_SEL_CMP:
            begin
                if (last_j)
                begin
                    state_next = S_SEL_END;
                end
                else
                begin
                    jdx_next = jdx_reg + KW'(1);
                end
            end
            S_SEL_END:
            begin
                if (last_i)
                begin
                    state_next = S_MEAN_GO;
                end
                else
                begin
                    idx_next   = idx_reg + KW'(1);
                    state_next = S_SEL_LOAD;
                end
            end
            S_MEAN_GO:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_AMB_MUL;
                end
            end
            S_AMB_MUL:
            begin
                state_next = S_AMB;
            end
            S_AMB:
            begin
                idx_next   = '0;
                state_next = S_CORR_MUL;
            end
            S_CORR_MUL:
            begin
                state_next = S_CORR_ADD;
            end
            S_CORR_ADD:
            begin
                if (last_i)
                begin
                    idx_next   = '0;
                    state_next = S_RANK_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + KW'(1);
                    state_next = S_CORR_MUL;
                end
            end
            S_RANK_LOAD:
            begin
                jdx_next   = '0;
                state_next = S_RANK_CMP;
            end
            S_RANK_CMP:
            begin
                if (last_j)
                begin
                    state_next = S_RANK_END;
                end
                else
                begin
                    jdx_next = jdx_reg + KW'(1);
                end
            end
            S_RANK_END:
            begin
                if (last_i)
                begin
                    state_next = S_FC_GO;
                end
                else
                begin
                    idx_next   = idx_reg + KW'(1);
                    state_next = S_RANK_LOAD;
                end
            end
            S_FC_GO:
            begin
                state_next = fv ? S_FC_WAIT : S_SOA_GO;
            end
            S_FC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SOA_GO;
                end
            end
            S_SOA_GO:
            begin
                idx_next   = '0;
                kcnt_next  = '0;
                state_next = sv ? S_SOA_WAIT : S_EMIT;
            end
            S_SOA_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (cand)
                begin
                    if (can_load)
                    begin
                        load_out    = 1'b1;
                        ovalid_next = 1'b1;
                        kcnt_next   = kcnt_reg + KW'(1);
                        idx_next    = idx_reg + KW'(1);
                        if (kcnt_reg == ne - KW'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + KW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            jdx_reg    <= '0;
            kcnt_reg   <= '0;
            ptr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            jdx_reg    <= jdx_next;
            kcnt_reg   <= kcnt_next;
            ptr_reg    <= ptr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    if (!head.item.is_count)
                    begin
                        prop_mem[IW'(head.item.row)] <= head.item.value;
                    end
                    else
                    begin
                        if (ptr_reg < KW'(MAX_ROWS))
                        begin
                            cnt_mem[ptr_reg[IW-1:0]] <= head.item.value;
                        end
                        if (head.item.cell_end)
                        begin
                            sum_reg  <= '0;
                            perr_reg <= 1'b0;
                        end
                    end
                end
            end
            S_RAT_GO:
            begin
                sum_reg <= sum_reg + SW'(prop_rd);
                if (prop_rd == '0)
                begin
                    perr_reg <= 1'b1;
                end
            end
            S_RAT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ratio_mem[i_addr] <= div_rsp.quo;
                end
            end
            S_SEL_LOAD:
            begin
                cur_reg <= WIDE_W'(rat_rd);
                gt_reg  <= '0;
                ge_reg  <= '0;
            end
            S_SEL_CMP:
            begin
                if (rat_rd > cur_reg[Q_W-1:0])
                begin
                    gt_reg <= gt_reg + KW'(1);
                end
                if (rat_rd >= cur_reg[Q_W-1:0])
                begin
                    ge_reg <= ge_reg + KW'(1);
                end
            end
            S_SEL_END:
            begin
                // This ratio occupies descending ranks gt to ge-1 of the sorted list.
                if ((gt_reg <= ka) && (ka < ge_reg))
                begin
                    sela_reg <= cur_reg[Q_W-1:0];
                end
                if ((gt_reg <= kb) && (kb < ge_reg))
                begin
                    selb_reg <= cur_reg[Q_W-1:0];
                end
            end
            S_MEAN_GO:
            begin
                scaling_reg <= (use_med && even) ? pair_sum[Q_W:1] : selb_reg;
            end
            S_MEAN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mean_reg <= div_rsp.quo[VAL_W-1:0];
                end
            end
            S_AMB_MUL:
            begin
                prod_reg <= scaling_reg * mean_reg;
            end
            S_AMB:
            begin
                amb_reg <= (ex_val < cfg.pseudo_floor) ? cfg.pseudo_floor : ex_val;
            end
            S_CORR_MUL:
            begin
                prod_reg <= scaling_reg * prop_rd;
                obs_reg  <= {cnt_rd, 16'd0};
            end
            S_CORR_ADD:
            begin
                corr_mem[i_addr] <= corr_sat;
            end
            S_RANK_LOAD:
            begin
                cur_reg <= corr_rd;
                gt_reg  <= '0;
            end
            S_RANK_CMP:
            begin
                // Ties go to the higher row index.
                if ((corr_rd > cur_reg) || ((corr_rd == cur_reg) && (jdx_reg > idx_reg)))
                begin
                    gt_reg <= gt_reg + KW'(1);
                end
            end
            S_RANK_END:
            begin
                pos_mem[i_addr] <= gt_reg;
                if (gt_reg == ne - KW'(1))
                begin
                    vala_reg <= cur_reg;
                end
                if (gt_reg == ne)
                begin
                    valb_reg <= cur_reg;
                    sidx_reg <= idx_reg;
                end
            end
            S_FC_GO:
            begin
                fc_reg <= '0;
            end
            S_FC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fc_reg <= div_rsp.quo;
                end
            end
            S_SOA_GO:
            begin
                soa_reg <= '0;
            end
            S_SOA_WAIT:
            begin
                if (div_rsp.done)
                begin
                    soa_reg <= div_rsp.quo;
                end
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    o_best_index_reg   <= bv ? ROW_W'(idx_reg) : '0;
                    o_best_valid_reg   <= bv;
                    o_fold_change_reg  <= fc_reg;
                    o_fold_valid_reg   <= fv;
                    o_second_index_reg <= sv ? ROW_W'(sidx_reg) : '0;
                    o_second_valid_reg <= sv;
                    o_second_value_reg <= sv ? valb_reg : '0;
                    o_soa_reg          <= soa_reg;
                    o_ambient_reg      <= amb_reg;
                    o_perr_reg         <= perr_reg;
                    o_last_reg         <= (kcnt_reg == ne - KW'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid               = ovalid_reg;
    assign out_ch.best_index          = o_best_index_reg;
    assign out_ch.best_valid          = o_best_valid_reg;
    assign out_ch.fold_change         = o_fold_change_reg;
    assign out_ch.fold_valid          = o_fold_valid_reg;
    assign out_ch.second_index        = o_second_index_reg;
    assign out_ch.second_valid        = o_second_valid_reg;
    assign out_ch.second_value        = o_second_value_reg;
    assign out_ch.second_over_ambient = o_soa_reg;
    assign out_ch.ambient_level       = o_ambient_reg;
    assign out_ch.prop_error          = o_perr_reg;
    assign out_ch.run_last            = o_last_reg;

endmodule
`default_nettype wire

// ----- rtl/hashtag_ambient_delta_ranker.sv -----
`default_nettype none
// ============================================================================
// hashtag_ambient_delta_ranker: ambient-corrected ranking of tag counts
// Loads proportions, collects one cell's counts and emits its top rows.
// ============================================================================
//
//   Channel   Direction  Transfer contents
//   -------   ---------  ----------------------------------------------------
//   in_ch     sink       proportion write or one count (op, row, value, end)
//   out_ch    source     one top-ranked row with the cell's statistics
//   cfg_*     write      rows in use, expected count, pseudo floor
//
// A proportion write or a count that does not end a cell is handled by the
// sequencer in its idle state. The count that ends a cell starts an evaluation
// of the nr rows in use, paced by the radix-2 divider (one quotient bit per
// cycle) and the two pairwise compare loops. Reset clears control state only;
// the tables are undefined until written. The two-entry queue keeps accepting
// transfers while the sequencer is busy, until both entries are full; the
// result register lets it run on while out_ch stalls, but a new row waits.
// ============================================================================
module hashtag_ambient_delta_ranker #(
    parameter int MAX_ROWS     = 16,
    parameter int MAX_EXPECTED = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hadr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hadr_pkg::WIDE_W-1:0]       cfg_data,
    hadr_in_if.sink                                in_ch,
    hadr_out_if.source                             out_ch
);
    import hadr_pkg::*;

    logic [4:0]        rows_reg;
    logic [3:0]        expected_reg;
    logic [WIDE_W-1:0] floor_reg;
    hadr_cfg_t         cfg;
    hadr_qhead_t       head;
    logic              pop;
    hadr_div_req_t     div_req;
    hadr_div_rsp_t     div_rsp;

    // Configuration registers; write them only while idle; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= 5'd16;
            expected_reg <= 4'd1;
            floor_reg    <= 40'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS:     rows_reg     <= cfg_data[4:0];
                CFG_EXPECTED: expected_reg <= cfg_data[3:0];
                CFG_FLOOR:    floor_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.rows         = rows_reg;
    assign cfg.expected     = expected_reg;
    assign cfg.pseudo_floor = floor_reg;

    // Front: takes transfers, filters out-of-table writes, queues the rest.
    hadr_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    // Shared divider for ratios, the mean proportion and the two quotients.
    hadr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back: table updates and the per-cell evaluation sequence.
    hadr_back #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_EXPECTED (MAX_EXPECTED)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .pop     (pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for hashtag_ambient_delta_ranker
// Loads proportion tables, streams cells of counts under several register
// settings with bursty input and a stalling result channel, and checks every
// result transfer against a cycle-free prediction of the ranking.
// ============================================================================
module tb;
    import hadr_pkg::*;

    localparam int ROWS_MAX   = 16;
    localparam int EXP_MAX    = 8;
    localparam int DRAIN_WAIT = 1600;     // longer than an evaluation of 16 rows
    localparam int LIMIT      = 1000000;
    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 18;

    // One result transfer as seen on out_ch.
    typedef struct {
        logic [ROW_W-1:0]  best_index;
        logic              best_valid;
        logic [Q_W-1:0]    fold_change;
        logic              fold_valid;
        logic [ROW_W-1:0]  second_index;
        logic              second_valid;
        logic [WIDE_W-1:0] second_value;
        logic [Q_W-1:0]    second_over_ambient;
        logic [WIDE_W-1:0] ambient_level;
        logic              prop_error;
        logic              run_last;
    } ranked_row_t;

    // One row of the directed table. Where err_known is set, the error flag of
    // the resulting cell is typed in rather than taken from the predictor.
    typedef struct {
        logic             op;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] value;
        logic             last;
        bit               err_known;
        bit               err_flag;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDE_W-1:0] cfg_data;

    hadr_in_if  in_ch ();
    hadr_out_if out_ch ();

    hashtag_ambient_delta_ranker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state: our own copy of the tables and the registers.
    logic [VAL_W-1:0]  prop_mem [ROWS_MAX];
    logic [VAL_W-1:0]  count_mem [ROWS_MAX];
    int                count_ptr;
    logic [4:0]        rows_reg;
    logic [3:0]        expected_reg;
    logic [WIDE_W-1:0] floor_reg;

    ranked_row_t       pending_rows[$];
    int                mismatches;
    int                cycle_count;
    int                burst_left;
    bit                steady_send;

    // The first cells after reset exercise error handling and extremes; the
    // tables have been fully loaded before any of these rows is sent.
    stim_row_t directed_rows [18] = '{
        '{OP_PROP,  4'd3,  24'd0,        1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd0,  24'hFFFFFF,   1'b1, 1'b1, 1'b1},  // short cell, zero proportion
        '{OP_PROP,  4'd3,  24'hFFFFFF,   1'b1, 1'b0, 1'b0},  // cell end ignored on writes
        '{OP_COUNT, 4'd0,  24'd0,        1'b1, 1'b1, 1'b0},
        '{OP_PROP,  4'd15, 24'd1,        1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd9,  24'd100,      1'b0, 1'b0, 1'b0},
        '{OP_PROP,  4'd0,  24'd65536,    1'b0, 1'b0, 1'b0},  // written while a cell is open
        '{OP_COUNT, 4'd0,  24'hFFFFFF,   1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd0,  24'd0,        1'b1, 1'b1, 1'b0},
        '{OP_PROP,  4'd7,  24'd0,        1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd5,  24'd65535,    1'b1, 1'b1, 1'b1},
        '{OP_PROP,  4'd7,  24'h800000,   1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd0,  24'h000001,   1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd15, 24'h800000,   1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd0,  24'h7FFFFF,   1'b1, 1'b1, 1'b0},
        '{OP_COUNT, 4'd0,  24'd0,        1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd0,  24'd0,        1'b0, 1'b0, 1'b0},
        '{OP_COUNT, 4'd0,  24'd0,        1'b1, 1'b1, 1'b0}
    };

    always #2 clk = ~clk;

    // The run is cut short as failed when cycle_count reaches LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Q16.16 quotient with saturation; a zero divisor saturates as well.
    function automatic logic [63:0] q16_quot(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (den == 0)
            return 64'hFFFF_FFFF;
        q = (num << 16) / den;
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    // Updates the predicted tables for one accepted transfer and, when it
    // closes a cell, queues the result transfers of that cell.
    task automatic predict_transfer(input stim_row_t s);
        logic [63:0] ratio [ROWS_MAX];
        logic [63:0] corr [ROWS_MAX];
        int          order [ROWS_MAX];
        int          best [EXP_MAX];
        logic [63:0] sum, mean, scaling, amb, tmp, obs, ex, fc, sval, soa;
        int          nr, ne, half, fb, i, j, t, sidx;
        bit          perr, bv, fv, sv, ahead;
        ranked_row_t r;

        if (s.op == OP_PROP)
        begin
            prop_mem[s.row] = s.value;
            return;
        end
        if (count_ptr < ROWS_MAX)
        begin
            count_mem[count_ptr] = s.value;
            count_ptr++;
        end
        if (!s.last)
            return;
        count_ptr = 0;

        nr = (rows_reg < 1) ? 1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : int'(rows_reg);
        ne = (expected_reg < 1) ? 1 : (expected_reg > EXP_MAX) ? EXP_MAX
                                                               : int'(expected_reg);
        sum  = 0;
        perr = 0;
        for (i = 0; i < nr; i++)
        begin
            sum += 64'(prop_mem[i]);
            if (prop_mem[i] == 0)
            begin
                perr = 1;
                ratio[i] = 64'hFFFF_FFFF;
            end
            else
            begin
                tmp = (64'(count_mem[i]) << 32) / prop_mem[i];
                ratio[i] = (tmp > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : tmp;
            end
        end
        mean = sum / nr;

        // Ratios in descending order.
        for (i = 1; i < nr; i++)
        begin
            tmp = ratio[i];
            j = i;
            while (j > 0 && ratio[j-1] < tmp)
            begin
                ratio[j] = ratio[j-1];
                j--;
            end
            ratio[j] = tmp;
        end

        half = nr / 2;
        fb = (2 * ne > nr - 1) ? nr - 1 : 2 * ne;
        if (half > fb)
            scaling = (nr % 2 == 0) ? (ratio[half-1] + ratio[half]) / 2 : ratio[half];
        else
            scaling = ratio[fb];

        amb = (scaling * mean) >> 16;
        if (amb < floor_reg)
            amb = 64'(floor_reg);

        for (i = 0; i < nr; i++)
        begin
            obs = 64'(count_mem[i]) << 16;
            ex  = (scaling * prop_mem[i]) >> 16;
            tmp = ((obs > ex) ? obs - ex : 0) + amb;
            corr[i] = (tmp > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : tmp;
            order[i] = i;
        end

        // Rank rows: larger corrected value first, ties to the higher row.
        for (i = 1; i < nr; i++)
        begin
            t = order[i];
            j = i;
            ahead = 1;
            while (j > 0 && ahead)
            begin
                ahead = (corr[t] > corr[order[j-1]]) ||
                        (corr[t] == corr[order[j-1]] && t > order[j-1]);
                if (ahead)
                begin
                    order[j] = order[j-1];
                    j--;
                end
            end
            order[j] = t;
        end

        bv = nr >= ne;
        fv = nr > ne;
        sv = nr > 2 * ne;

        for (i = 0; i < ne; i++)
            best[i] = bv ? order[i] : 0;
        for (i = 1; i < ne; i++)
        begin
            t = best[i];
            j = i;
            while (j > 0 && best[j-1] > t)
            begin
                best[j] = best[j-1];
                j--;
            end
            best[j] = t;
        end

        fc = fv ? q16_quot(corr[order[ne-1]], corr[order[ne]]) : 0;
        sidx = 0;
        sval = 0;
        soa  = 0;
        if (sv)
        begin
            sidx = order[ne];
            sval = corr[sidx];
            soa  = q16_quot(sval, amb);
        end

        for (i = 0; i < ne; i++)
        begin
            r.best_index          = ROW_W'(best[i]);
            r.best_valid          = bv;
            r.fold_change         = fc[Q_W-1:0];
            r.fold_valid          = fv;
            r.second_index        = ROW_W'(sidx);
            r.second_valid        = sv;
            r.second_value        = sval[WIDE_W-1:0];
            r.second_over_ambient = soa[Q_W-1:0];
            r.ambient_level       = amb[WIDE_W-1:0];
            r.prop_error          = s.err_known ? s.err_flag : perr;
            r.run_last            = (i == ne - 1);
            pending_rows.push_back(r);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatches < 10)
            $display("mismatch at cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, want, got);
        mismatches++;
    endtask

    // Result side: checks each transfer and stalls on a pattern, redrawn
    // periodically, among free flow, random, sparse and long stalls.
    int stall_mode;
    int stall_left;
    always @(posedge clk)
    begin
        ranked_row_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_rows.size() == 0)
                note_mismatch("result with nothing pending", 64'd0,
                              64'(out_ch.best_index));
            else
            begin
                e = pending_rows.pop_front();
                if (e.best_index != out_ch.best_index)
                    note_mismatch("best_index", 64'(e.best_index),
                                  64'(out_ch.best_index));
                if (e.best_valid != out_ch.best_valid)
                    note_mismatch("best_valid", 64'(e.best_valid),
                                  64'(out_ch.best_valid));
                if (e.fold_change != out_ch.fold_change)
                    note_mismatch("fold_change", 64'(e.fold_change),
                                  64'(out_ch.fold_change));
                if (e.fold_valid != out_ch.fold_valid)
                    note_mismatch("fold_valid", 64'(e.fold_valid),
                                  64'(out_ch.fold_valid));
                if (e.second_index != out_ch.second_index)
                    note_mismatch("second_index", 64'(e.second_index),
                                  64'(out_ch.second_index));
                if (e.second_valid != out_ch.second_valid)
                    note_mismatch("second_valid", 64'(e.second_valid),
                                  64'(out_ch.second_valid));
                if (e.second_value != out_ch.second_value)
                    note_mismatch("second_value", 64'(e.second_value),
                                  64'(out_ch.second_value));
                if (e.second_over_ambient != out_ch.second_over_ambient)
                    note_mismatch("second_over_ambient", 64'(e.second_over_ambient),
                                  64'(out_ch.second_over_ambient));
                if (e.ambient_level != out_ch.ambient_level)
                    note_mismatch("ambient_level", 64'(e.ambient_level),
                                  64'(out_ch.ambient_level));
                if (e.prop_error != out_ch.prop_error)
                    note_mismatch("prop_error", 64'(e.prop_error),
                                  64'(out_ch.prop_error));
                if (e.run_last != out_ch.run_last)
                    note_mismatch("run_last", 64'(e.run_last), 64'(out_ch.run_last));
            end
        end
        if (cycle_count % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= (cycle_count % 8 == 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left = stall_left - 1;
                    out_ch.ready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 30);
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // Sends one transfer, in bursts of random length separated by random gaps.
    // The prediction is taken at the edge at which the transfer is accepted.
    task automatic send(input stim_row_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_send ? 0 : ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                                 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= s.op;
        in_ch.row          <= s.row;
        in_ch.sample_value <= s.value;
        in_ch.cell_end     <= s.last;
        do @(posedge clk); while (!in_ch.ready);
        predict_transfer(s);
        burst_left--;
    endtask

    task automatic send_plain(input logic op, input logic [ROW_W-1:0] row,
                              input logic [VAL_W-1:0] value, input logic last);
        stim_row_t s;
        s = '{op, row, value, last, 1'b0, 1'b0};
        send(s);
    endtask

    // Lets every pending result arrive and the evaluator settle, so that the
    // registers can be rewritten safely.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_rows.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDE_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROWS:     rows_reg = data[4:0];
            CFG_EXPECTED: expected_reg = data[3:0];
            CFG_FLOOR:    floor_reg = data;
            default: ;
        endcase
    endtask

    function automatic logic [VAL_W-1:0] pick_count();
        case ($urandom_range(0, 4))
            0: return VAL_W'($urandom_range(0, 255));
            1: return VAL_W'($urandom);
            2: return VAL_W'($urandom_range(0, 4095));
            3: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_prop();
        case ($urandom_range(0, 19))
            0: return 24'd0;
            1: return VAL_W'($urandom);
            2: return 24'hFFFFFF;
            default: return VAL_W'($urandom_range(1, 24'h20000));
        endcase
    endfunction

    initial
    begin
        int nr, n, k, sent, ph;
        logic [4:0]        rows_set [PHASES];
        logic [3:0]        exp_set [PHASES];
        logic [WIDE_W-1:0] floor_set [PHASES];

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_PROP;
        in_ch.row = '0;
        in_ch.sample_value = '0;
        in_ch.cell_end = 1'b0;
        out_ch.ready = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        burst_left = 0;
        steady_send = 0;
        stall_mode = 0;
        stall_left = 0;
        count_ptr = 0;
        rows_reg = 5'd16;
        expected_reg = 4'd1;
        floor_reg = 40'd65536;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill both tables so that no later cell reads an unwritten entry.
        for (k = 0; k < ROWS_MAX; k++)
            send_plain(OP_PROP, ROW_W'(k), VAL_W'($urandom_range(1, 24'h20000)), 1'b0);
        for (k = 0; k < ROWS_MAX; k++)
            send_plain(OP_COUNT, ROW_W'(0), pick_count(), k == ROWS_MAX - 1);

        foreach (directed_rows[i])
            send(directed_rows[i]);

        // Register settings: the extremes first, then random ones which also
        // cover the out-of-range values that the block clamps.
        rows_set[0] = 5'd1;  exp_set[0] = 4'd1;  floor_set[0] = 40'd1;
        rows_set[1] = 5'd16; exp_set[1] = 4'd8;  floor_set[1] = 40'hFF_FFFF_FFFF;
        rows_set[2] = 5'd3;  exp_set[2] = 4'd8;  floor_set[2] = 40'd65536;
        rows_set[3] = 5'd16; exp_set[3] = 4'd1;  floor_set[3] = 40'd1;
        rows_set[4] = 5'd0;  exp_set[4] = 4'd0;  floor_set[4] = 40'h12_3456;
        rows_set[5] = 5'd31; exp_set[5] = 4'd15; floor_set[5] = 40'd2;
        for (ph = 6; ph < PHASES; ph++)
        begin
            rows_set[ph] = 5'($urandom_range(0, 31));
            exp_set[ph] = 4'($urandom_range(0, 15));
            floor_set[ph] = WIDE_W'({$urandom_range(0, 255), $urandom}
                                    >> $urandom_range(0, 39));
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_reg(CFG_ROWS, WIDE_W'(rows_set[ph]));
            write_reg(CFG_EXPECTED, WIDE_W'(exp_set[ph]));
            write_reg(CFG_FLOOR, floor_set[ph]);
            steady_send = (ph % 4 == 1);
            nr = (rows_reg < 1) ? 1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : int'(rows_reg);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // A few fresh proportions, then a cell that is mostly full
                // length, sometimes short or overlong.
                for (k = $urandom_range(0, 3); k > 0; k--)
                begin
                    send_plain(OP_PROP, ROW_W'($urandom), pick_prop(),
                               1'($urandom_range(0, 1)));
                    sent++;
                end
                case ($urandom_range(0, 7))
                    0: n = $urandom_range(1, nr);
                    1: n = $urandom_range(nr, 20);
                    default: n = nr;
                endcase
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        send_plain(OP_PROP, ROW_W'($urandom), pick_prop(), 1'b0);
                        sent++;
                    end
                    send_plain(OP_COUNT, ROW_W'($urandom), pick_count(), k == n - 1);
                    sent++;
                end
            end
        end

        settle();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/hadr_pkg.sv
rtl/hadr_in_if.sv
rtl/hadr_out_if.sv
rtl/hadr_front.sv
rtl/hadr_div.sv
rtl/hadr_back.sv
rtl/hashtag_ambient_delta_ranker.sv
verif/tb.sv
